// ----- design/stroke_point_smoother_unit_macros.svh -----
// Assertion macros for the stroke point smoother.
// Used by the top level; no dependencies.
`ifndef STROKE_POINT_SMOOTHER_UNIT_MACROS_SVH
`define STROKE_POINT_SMOOTHER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SPS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPS_ASSERT_IMP(name, ante, cons, msg)
`define SPS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- design/sps_pkg.sv -----
// Package of the stroke point smoother: widths, codes and the Gaussian weight table.
// No dependencies.
package sps_pkg;

    localparam int COORD_W    = 24;
    localparam int PRES_W     = 16;
    localparam int CNT_W      = 6;
    localparam int MODE_W     = 2;
    localparam int STR_W      = 5;
    localparam int TAP_W      = 5;
    localparam int W_W        = 17;
    localparam int PROD_W     = 42;
    localparam int ACC_W      = 46;
    localparam int DEN_W      = 22;
    localparam int Q_W        = 24;
    localparam int DCNT_W     = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int APB_W      = 32;

    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 1'b1;

    typedef logic [31:0][31:0][W_W-1:0] gauss_rom_t;

    function automatic logic [W_W-1:0] gauss_weight(input int unsigned s, input int unsigned i);
        longint unsigned ss;
        longint unsigned ii;
        longint unsigned d;
        longint unsigned num;
        longint unsigned den2;
        longint unsigned rem;
        longint unsigned quo;
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned e;
        longint signed   sum;
        int              b;
        ss   = longint'(s);
        ii   = longint'(i);
        d    = 2 * (ss + 1) * (ss + 1);
        num  = 9 * ii * ii * 131072 + d;
        den2 = 2 * d;
        rem  = 0;
        quo  = 0;
        for (b = 31; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den2)
            begin
                rem = rem - den2;
                quo = quo | (64'd1 << b);
            end
        end
        n = quo >> 16;
        f = quo & 64'hFFFF;
        if (n > 4)
        begin
            n = 4;
        end
        term = 65536;
        sum  = 65536;
        term = (term * f) / 65536;
        sum  = sum - longint'(term);
        term = (term * f) / 131072;
        sum  = sum + longint'(term);
        term = (term * f) / 196608;
        sum  = sum - longint'(term);
        term = (term * f) / 262144;
        sum  = sum + longint'(term);
        term = (term * f) / 327680;
        sum  = sum - longint'(term);
        term = (term * f) / 393216;
        sum  = sum + longint'(term);
        term = (term * f) / 458752;
        sum  = sum - longint'(term);
        term = (term * f) / 524288;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        case (n)
            0:       e = 65536;
            1:       e = 24109;
            2:       e = 8869;
            3:       e = 3263;
            default: e = 1200;
        endcase
        return W_W'((e * longint'(sum) + 32768) >> 16);
    endfunction

    function automatic gauss_rom_t gauss_rom_build();
        gauss_rom_t rom;
        int         s;
        int         i;
        for (s = 0; s < 32; s++)
        begin
            for (i = 0; i < 32; i++)
            begin
                rom[s][i] = gauss_weight(s, i);
            end
        end
        return rom;
    endfunction

    localparam gauss_rom_t GAUSS_ROM = gauss_rom_build();

endpackage

// ----- design/stroke_point_smoother_unit.sv -----
// Stroke point smoother: ring of pen points, weighted average by a shared MAC per axis
// and bit-serial rounding dividers. Depends on sps_pkg and the assertion macro header.
//
// Usage:
// Input words (cmd, pos_x, pos_y, pressure, fill_count) are taken when in_valid is high
// and in_stall is low; in_stall is high whenever an earlier word is still being worked on.
// A start word (cmd 0) writes the point into fill_count ring entries, one per cycle, and
// gives no result; the next word is taken once the fill is done.
// An add word (cmd 1) stores the point and gives one output word. Unsmoothed, it goes
// straight to the output state, which loads the output register and raises out_valid;
// the next word is taken when that state is left. Smoothed, the taps are read in turn
// through the single ring read port and the MACs, the pipeline drains, a setup state
// loads the dividers, the dividers yield one quotient bit per cycle for the 24 quotient
// bits, and the output state loads the output register; the next word is then taken.
// The output register holds a word until out_stall is low; a new result waits in the
// output state while that register is full and stalled; no input is taken meanwhile.
// smoothing_mode and strength are to be written over the APB port while the block is
// idle; the block itself does not enforce this. Reset clears the control registers and
// the write index; ring contents are undefined until a start word writes them.
`include "stroke_point_smoother_unit_macros.svh"

module stroke_point_smoother_unit #(
    parameter int RING_DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sps_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sps_pkg::APB_W-1:0]           pwdata,
    output logic [sps_pkg::APB_W-1:0]           prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic signed [sps_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [sps_pkg::COORD_W-1:0]  pos_y,
    input  logic [sps_pkg::PRES_W-1:0]          pressure,
    input  logic [sps_pkg::CNT_W-1:0]           fill_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sps_pkg::COORD_W-1:0]  out_x,
    output logic signed [sps_pkg::COORD_W-1:0]  out_y,
    output logic [sps_pkg::PRES_W-1:0]          out_pressure
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [sps_pkg::DCNT_W-1:0] DIV_LAST = sps_pkg::DCNT_W'(sps_pkg::Q_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_TAP,
        S_DRAIN,
        S_DIV_INIT,
        S_DIV,
        S_OUT
    } state_t;

    state_t                              state_reg;
    logic [sps_pkg::MODE_W-1:0]          mode_reg;
    logic [sps_pkg::STR_W-1:0]           strength_reg;
    logic [IDX_W-1:0]                    wr_idx_reg;
    logic [IDX_W-1:0]                    addr_reg;
    logic [IDX_W-1:0]                    newest_reg;
    logic [sps_pkg::CNT_W-1:0]           cnt_reg;
    logic [sps_pkg::TAP_W-1:0]           tap_reg;
    logic [sps_pkg::DCNT_W-1:0]          dcnt_reg;
    logic                                rd_v_reg;
    logic                                prod_v_reg;
    logic                                out_valid_reg;

    logic signed [sps_pkg::COORD_W-1:0]  x_reg;
    logic signed [sps_pkg::COORD_W-1:0]  y_reg;
    logic [sps_pkg::PRES_W-1:0]          pr_reg;
    logic signed [sps_pkg::COORD_W-1:0]  rd_x_reg;
    logic signed [sps_pkg::COORD_W-1:0]  rd_y_reg;
    logic [sps_pkg::W_W-1:0]             w_reg;
    logic signed [sps_pkg::PROD_W-1:0]   prod_x_reg;
    logic signed [sps_pkg::PROD_W-1:0]   prod_y_reg;
    logic signed [sps_pkg::ACC_W-1:0]    acc_x_reg;
    logic signed [sps_pkg::ACC_W-1:0]    acc_y_reg;
    logic [sps_pkg::DEN_W-1:0]           den_reg;
    logic [sps_pkg::ACC_W-1:0]           rem_x_reg;
    logic [sps_pkg::ACC_W-1:0]           rem_y_reg;
    logic [sps_pkg::ACC_W-1:0]           dsh_reg;
    logic [sps_pkg::Q_W-1:0]             q_x_reg;
    logic [sps_pkg::Q_W-1:0]             q_y_reg;
    logic                                neg_x_reg;
    logic                                neg_y_reg;
    logic [sps_pkg::COORD_W-1:0]         res_x_reg;
    logic [sps_pkg::COORD_W-1:0]         res_y_reg;
    logic [sps_pkg::COORD_W-1:0]         out_x_reg;
    logic [sps_pkg::COORD_W-1:0]         out_y_reg;
    logic [sps_pkg::PRES_W-1:0]          out_pr_reg;

    logic [sps_pkg::COORD_W-1:0]         ring_x_mem [RING_DEPTH];
    logic [sps_pkg::COORD_W-1:0]         ring_y_mem [RING_DEPTH];

    logic                                accept;
    logic                                smooth_on;
    logic                                out_free;
    logic                                cfg_wr;
    logic [sps_pkg::CFG_IDX_W-1:0]       cfg_idx;
    logic                                mem_we;
    logic [IDX_W-1:0]                    mem_addr;
    logic [sps_pkg::COORD_W-1:0]         mem_wx;
    logic [sps_pkg::COORD_W-1:0]         mem_wy;
    logic [sps_pkg::W_W-1:0]             tap_weight;
    logic [sps_pkg::ACC_W-1:0]           mag_x;
    logic [sps_pkg::ACC_W-1:0]           mag_y;
    logic                                ge_x;
    logic                                ge_y;
    logic [sps_pkg::ACC_W-1:0]           rem_x_step;
    logic [sps_pkg::ACC_W-1:0]           rem_y_step;
    logic [sps_pkg::Q_W-1:0]             q_x_step;
    logic [sps_pkg::Q_W-1:0]             q_y_step;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign smooth_on = (mode_reg != sps_pkg::MODE_NONE) && (strength_reg != '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[sps_pkg::CFG_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            sps_pkg::REG_MODE:     prdata[sps_pkg::MODE_W-1:0] = mode_reg;
            sps_pkg::REG_STRENGTH: prdata[sps_pkg::STR_W-1:0]  = strength_reg;
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        unique case (mode_reg)
            sps_pkg::MODE_UNIFORM: tap_weight = sps_pkg::W_W'(1);
            sps_pkg::MODE_LINEAR:  tap_weight = sps_pkg::W_W'(strength_reg)
                                                + sps_pkg::W_W'(1)
                                                - sps_pkg::W_W'(tap_reg);
            sps_pkg::MODE_GAUSS:   tap_weight = sps_pkg::GAUSS_ROM[strength_reg][tap_reg];
            default:               tap_weight = '0;
        endcase
    end

    // Ring port: the new point in the accept cycle, fill sweep, tap reads, write-back.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wx = res_x_reg;
        mem_wy = res_y_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_addr = wr_idx_reg;
                mem_we   = accept && cmd;
                mem_wx   = pos_x;
                mem_wy   = pos_y;
            end
            S_FILL:
            begin
                mem_addr = addr_reg;
                mem_we   = 1'b1;
                mem_wx   = x_reg;
                mem_wy   = y_reg;
            end
            S_OUT:
            begin
                mem_addr = newest_reg;
                mem_we   = 1'b1;
            end
            default:
            begin
                mem_addr = addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_x_mem[mem_addr] <= mem_wx;
            ring_y_mem[mem_addr] <= mem_wy;
        end
        rd_x_reg <= ring_x_mem[mem_addr];
        rd_y_reg <= ring_y_mem[mem_addr];
    end

    always_comb
    begin
        mag_x      = acc_x_reg[sps_pkg::ACC_W-1] ? (~acc_x_reg + 1'b1) : acc_x_reg;
        mag_y      = acc_y_reg[sps_pkg::ACC_W-1] ? (~acc_y_reg + 1'b1) : acc_y_reg;
        ge_x       = (rem_x_reg >= dsh_reg);
        ge_y       = (rem_y_reg >= dsh_reg);
        rem_x_step = ge_x ? (rem_x_reg - dsh_reg) : rem_x_reg;
        rem_y_step = ge_y ? (rem_y_reg - dsh_reg) : rem_y_reg;
        q_x_step   = {q_x_reg[sps_pkg::Q_W-2:0], ge_x};
        q_y_step   = {q_y_reg[sps_pkg::Q_W-2:0], ge_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= sps_pkg::MODE_NONE;
            strength_reg  <= '0;
            wr_idx_reg    <= '0;
            addr_reg      <= '0;
            newest_reg    <= '0;
            cnt_reg       <= '0;
            tap_reg       <= '0;
            dcnt_reg      <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    sps_pkg::REG_MODE:     mode_reg     <= pwdata[sps_pkg::MODE_W-1:0];
                    sps_pkg::REG_STRENGTH: strength_reg <= pwdata[sps_pkg::STR_W-1:0];
                    default:               mode_reg     <= mode_reg;
                endcase
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_v_reg   <= (state_reg == S_TAP);
            prod_v_reg <= rd_v_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!cmd)
                        begin
                            addr_reg <= '0;
                            cnt_reg  <= fill_count;
                            if (fill_count == '0)
                            begin
                                wr_idx_reg <= '0;
                            end
                            else
                            begin
                                state_reg <= S_FILL;
                            end
                        end
                        else
                        begin
                            newest_reg <= wr_idx_reg;
                            addr_reg   <= wr_idx_reg;
                            wr_idx_reg <= idx_inc(wr_idx_reg);
                            tap_reg    <= '0;
                            state_reg  <= smooth_on ? S_TAP : S_OUT;
                        end
                    end
                end
                S_FILL:
                begin
                    addr_reg <= idx_inc(addr_reg);
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == sps_pkg::CNT_W'(1))
                    begin
                        wr_idx_reg <= idx_inc(addr_reg);
                        state_reg  <= S_IDLE;
                    end
                end
                S_TAP:
                begin
                    addr_reg <= idx_dec(addr_reg);
                    tap_reg  <= tap_reg + 1'b1;
                    if (tap_reg == strength_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_v_reg && !prod_v_reg)
                    begin
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT:
                begin
                    dcnt_reg  <= DIV_LAST;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= tap_weight;
        if (accept)
        begin
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            pr_reg    <= pressure;
            res_x_reg <= pos_x;
            res_y_reg <= pos_y;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            den_reg   <= '0;
        end
        if (rd_v_reg)
        begin
            prod_x_reg <= rd_x_reg * $signed({1'b0, w_reg});
            prod_y_reg <= rd_y_reg * $signed({1'b0, w_reg});
            den_reg    <= den_reg + sps_pkg::DEN_W'(w_reg);
        end
        if (prod_v_reg)
        begin
            acc_x_reg <= acc_x_reg + sps_pkg::ACC_W'(prod_x_reg);
            acc_y_reg <= acc_y_reg + sps_pkg::ACC_W'(prod_y_reg);
        end
        if (state_reg == S_DIV_INIT)
        begin
            rem_x_reg <= (mag_x << 1) + sps_pkg::ACC_W'(den_reg);
            rem_y_reg <= (mag_y << 1) + sps_pkg::ACC_W'(den_reg);
            dsh_reg   <= sps_pkg::ACC_W'(den_reg) << sps_pkg::Q_W;
            neg_x_reg <= acc_x_reg[sps_pkg::ACC_W-1];
            neg_y_reg <= acc_y_reg[sps_pkg::ACC_W-1];
            q_x_reg   <= '0;
            q_y_reg   <= '0;
        end
        if (state_reg == S_DIV)
        begin
            rem_x_reg <= rem_x_step;
            rem_y_reg <= rem_y_step;
            dsh_reg   <= dsh_reg >> 1;
            q_x_reg   <= q_x_step;
            q_y_reg   <= q_y_step;
            if (dcnt_reg == '0)
            begin
                res_x_reg <= neg_x_reg ? (~q_x_step + 1'b1) : q_x_step;
                res_y_reg <= neg_y_reg ? (~q_y_step + 1'b1) : q_y_step;
            end
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_x_reg  <= res_x_reg;
            out_y_reg  <= res_y_reg;
            out_pr_reg <= pr_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_pressure = out_pr_reg;

    `SPS_ASSERT_IMP(a_out_from_seq, $rose(out_valid_reg), $past(state_reg == S_OUT),
        "Output word appeared outside the output state.")
    `SPS_ASSERT_IMP(a_den_nonzero, state_reg == S_DIV, den_reg != '0,
        "Divider running with a zero weight sum.")
    `SPS_ASSERT_NEXT(a_plain_add, accept && cmd && !smooth_on, state_reg == S_OUT,
        "Unsmoothed add did not go straight to the output state.")
    `SPS_ASSERT_IMP(a_idx_range, state_reg != S_FILL,
        (wr_idx_reg <= LAST_IDX) && (newest_reg <= LAST_IDX),
        "Ring index outside the ring.")

endmodule
